// ===== design/bitmap_page_allocator_core_macros.svh =====
// Assertion macros for the bitmap page allocator checker.
// Needs i_clk and i_rst_n in the scope of each use.
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_MACROS_SVH

// cond must hold in the same cycle as en
`define BPA_ASSERT_NOW(lbl, en, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (en) |-> (cond)) \
        else $error(msg);

// cond must hold in the cycle after en
`define BPA_ASSERT_NEXT(lbl, en, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (en) |=> (cond)) \
        else $error(msg);

`endif

// ===== design/bpa_pkg.sv =====
// Shared types and codes for the bitmap page allocator.
// No dependencies.
package bpa_pkg;

    localparam int WORD_BITS = 64;

    localparam logic [1:0] OP_ALLOC_PAGE = 2'd0;
    localparam logic [1:0] OP_ALLOC_RUN  = 2'd1;
    localparam logic [1:0] OP_FREE_RUN   = 2'd2;
    localparam logic [1:0] OP_MARK       = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NO_MEM  = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [47:0] byte_address;
        logic [15:0] page_count;
        logic [47:0] region_length;
        logic        mark_used;
    } t_req;

    typedef struct packed {
        logic [26:0] page_address;
        logic [1:0]  status;
    } t_rsp;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_LOAD,
        CMD_READ,
        CMD_SCAN_ONE,
        CMD_RUN_WORD,
        CMD_RUN_CHUNK,
        CMD_WRITE
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic word_last;
        logic wrapped;
        logic one_hit;
        logic run_hit;
        logic word_full;
        logic chunk_last;
        logic range_empty;
        logic range_last;
    } t_dp_status;

endpackage

// ===== design/bpa_ctrl.sv =====
// Sequencer for the bitmap page allocator.
// Depends on bpa_pkg; drives the commands of bpa_dp.
module bpa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bpa_pkg::t_req       i_in_req,
    input  logic                i_out_free,
    input  bpa_pkg::t_dp_status i_status,
    output bpa_pkg::t_cmd       o_cmd,
    output logic                o_fin
);
    import bpa_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ONE_RD,
        S_ONE_EV,
        S_RUN_RD,
        S_RUN_EV,
        S_RUN_CH,
        S_WR_RD,
        S_WR_WR,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        o_fin   = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd = CMD_CLEAR;
                if (i_status.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd = CMD_LOAD;
                    unique case (i_in_req.opcode)
                        OP_ALLOC_PAGE: n_state = S_ONE_RD;
                        OP_ALLOC_RUN: begin
                            priority if (i_in_req.page_count == 16'd0) n_state = S_FIN;
                            else if (i_in_req.page_count == 16'd1) n_state = S_ONE_RD;
                            else n_state = S_RUN_RD;
                        end
                        OP_FREE_RUN: n_state = S_WR_RD;
                        OP_MARK:     n_state = S_WR_RD;
                    endcase
                end
            end
            S_ONE_RD: begin
                o_cmd   = CMD_READ;
                n_state = S_ONE_EV;
            end
            S_ONE_EV: begin
                o_cmd = CMD_SCAN_ONE;
                if (i_status.one_hit || (i_status.word_last && i_status.wrapped))
                    n_state = S_FIN;
                else
                    n_state = S_ONE_RD;
            end
            S_RUN_RD: begin
                o_cmd   = CMD_READ;
                n_state = S_RUN_EV;
            end
            S_RUN_EV: begin
                o_cmd = CMD_RUN_WORD;
                priority if (!i_status.word_full) n_state = S_RUN_CH;
                else if (i_status.word_last) n_state = S_FIN;
                else n_state = S_RUN_RD;
            end
            S_RUN_CH: begin
                o_cmd = CMD_RUN_CHUNK;
                priority if (i_status.run_hit) n_state = S_WR_RD;
                else if (i_status.chunk_last)
                    n_state = i_status.word_last ? S_FIN : S_RUN_RD;
                else n_state = S_RUN_CH;
            end
            S_WR_RD: begin
                if (i_status.range_empty) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd   = CMD_READ;
                    n_state = S_WR_WR;
                end
            end
            S_WR_WR: begin
                o_cmd   = CMD_WRITE;
                n_state = i_status.range_last ? S_FIN : S_WR_RD;
            end
            S_FIN: begin
                if (i_out_free) begin
                    o_fin   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/bpa_dp.sv =====
// Datapath of the bitmap page allocator: bitmap memory, scan and range units.
// Depends on bpa_pkg; commanded by bpa_ctrl.
module bpa_dp #(
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bpa_pkg::t_cmd       i_cmd,
    input  bpa_pkg::t_req       i_in_req,
    output bpa_pkg::t_dp_status o_status,
    output bpa_pkg::t_rsp       o_rsp
);
    import bpa_pkg::*;

    localparam int PW     = ($clog2(NUM_PAGES + 1) > 7) ? $clog2(NUM_PAGES + 1) : 7;
    localparam int WIW    = PW - 5;
    localparam int NWORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int MAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int SH     = $clog2(PAGE_BYTES);
    localparam int FW     = 50;
    localparam int CW     = (PW > 16) ? PW : 16;
    localparam logic [WIW-1:0] LAST_W = WIW'(NWORDS - 1);
    localparam logic [FW-1:0]  N_F    = FW'(NUM_PAGES);
    localparam logic [PW-1:0]  N_P    = PW'(NUM_PAGES);

    logic [WORD_BITS-1:0] r_mem [NWORDS];
    logic [WORD_BITS-1:0] r_rd_data;
    logic [WIW-1:0]       r_wc;
    logic [2:0]           r_chunk;
    logic                 r_phase;
    logic [PW-1:0]        r_hint;
    logic [PW-1:0]        r_lo;
    logic [PW-1:0]        r_hl;
    logic                 r_empty;
    logic                 r_used;
    logic [PW-1:0]        r_run;
    logic [PW-1:0]        r_first;
    logic [15:0]          r_count;
    t_rsp                 r_res;

    logic [MAW-1:0]       v_addr;
    logic [WIW-1:0]       v_hint_w;
    logic [WIW-1:0]       v_lo_w;
    logic [WIW-1:0]       v_hl_w;
    logic                 v_word_last;
    logic [WORD_BITS-1:0] v_one_free;
    logic                 v_one_hit;
    logic [5:0]           v_one_bit;
    logic [PW-1:0]        v_one_page;
    logic [7:0]           v_chunk_bits;
    logic [PW-1:0]        v_wbase;
    logic [PW-1:0]        v_pg;
    logic [PW-1:0]        v_run;
    logic [PW-1:0]        v_first;
    logic [PW-1:0]        v_end;
    logic                 v_found;
    logic [WORD_BITS-1:0] v_lo_mask;
    logic [WORD_BITS-1:0] v_hi_mask;
    logic [WORD_BITS-1:0] v_rng_mask;
    logic [FW-1:0]        v_base;
    logic [FW-1:0]        v_lo_raw;
    logic [FW-1:0]        v_hi_raw;
    logic [PW-1:0]        v_lo;
    logic [PW-1:0]        v_hi;
    logic                 v_we;
    logic [WORD_BITS-1:0] v_wdata;

    function automatic logic [26:0] f_byte_addr(input logic [PW-1:0] p);
        logic [PW+SH-1:0] w;
        w = {p, {SH{1'b0}}};
        return 27'(w);
    endfunction

    assign v_addr      = r_wc[MAW-1:0];
    assign v_hint_w    = {1'b0, r_hint[PW-1:6]};
    assign v_lo_w      = {1'b0, r_lo[PW-1:6]};
    assign v_hl_w      = {1'b0, r_hl[PW-1:6]};
    assign v_word_last = (r_wc == LAST_W);
    assign v_wbase     = PW'({r_wc, 6'b000000});

    // single-page search: first pass starts at the hint bit
    always_comb begin
        v_one_free = ~r_rd_data;
        if (!r_phase && (r_wc == v_hint_w)) begin
            v_one_free = v_one_free & ({WORD_BITS{1'b1}} << r_hint[5:0]);
        end
        v_one_hit = |v_one_free;
        v_one_bit = 6'd0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v_one_free[i]) v_one_bit = 6'(i);
        end
        v_one_page = v_wbase | PW'(v_one_bit);
    end

    // run search over one byte of the word
    always_comb begin
        v_chunk_bits = r_rd_data[{r_chunk, 3'b000} +: 8];
        v_run   = r_run;
        v_first = r_first;
        v_end   = '0;
        v_found = 1'b0;
        v_pg    = '0;
        for (int j = 0; j < 8; j++) begin
            if (!v_found) begin
                v_pg = v_wbase | PW'({r_chunk, 3'(j)});
                if (v_chunk_bits[j]) begin
                    v_run = '0;
                end else begin
                    if (v_run == '0) v_first = v_pg;
                    v_run = v_run + 1'b1;
                    if (CW'(v_run) >= CW'(r_count)) begin
                        v_found = 1'b1;
                        v_end   = v_pg;
                    end
                end
            end
        end
    end

    // page range of a free or mark request, clamped to the bitmap
    always_comb begin
        v_base = FW'(i_in_req.byte_address >> SH);
        if (i_in_req.opcode == OP_FREE_RUN) begin
            v_lo_raw = v_base + FW'(i_in_req.byte_address == 48'd0);
            v_hi_raw = v_base + FW'(i_in_req.page_count);
        end else begin
            v_lo_raw = v_base;
            v_hi_raw = (FW'(i_in_req.byte_address) + FW'(i_in_req.region_length)
                        + FW'(PAGE_BYTES - 1)) >> SH;
        end
        v_lo = (v_lo_raw > N_F) ? N_P : PW'(v_lo_raw);
        v_hi = (v_hi_raw > N_F) ? N_P : PW'(v_hi_raw);
    end

    always_comb begin
        v_lo_mask  = (r_wc == v_lo_w) ? ({WORD_BITS{1'b1}} << r_lo[5:0]) : '1;
        v_hi_mask  = (r_wc == v_hl_w) ? ({WORD_BITS{1'b1}} >> (6'd63 - r_hl[5:0])) : '1;
        v_rng_mask = v_lo_mask & v_hi_mask;
    end

    always_comb begin
        v_we    = 1'b0;
        v_wdata = r_rd_data;
        unique case (i_cmd)
            CMD_CLEAR: begin
                v_we    = 1'b1;
                v_wdata = '1;
            end
            CMD_SCAN_ONE: begin
                v_we    = v_one_hit;
                v_wdata = r_rd_data | (WORD_BITS'(1) << v_one_bit);
            end
            CMD_WRITE: begin
                v_we    = 1'b1;
                v_wdata = r_used ? (r_rd_data | v_rng_mask) : (r_rd_data & ~v_rng_mask);
            end
            default: v_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (v_we) r_mem[v_addr] <= v_wdata;
        if (i_cmd == CMD_READ) r_rd_data <= r_mem[v_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc    <= '0;
            r_hint  <= '0;
            r_phase <= 1'b0;
            r_empty <= 1'b1;
        end else begin
            unique case (i_cmd)
                CMD_NONE, CMD_READ: begin
                end
                CMD_CLEAR: r_wc <= r_wc + 1'b1;
                CMD_LOAD: begin
                    r_res <= '{page_address: '0,
                               status: (i_in_req.opcode == OP_ALLOC_RUN &&
                                        i_in_req.page_count == 16'd0) ? ST_IGNORED : ST_DONE};
                    r_count <= i_in_req.page_count;
                    r_run   <= '0;
                    r_chunk <= '0;
                    unique case (i_in_req.opcode)
                        OP_ALLOC_PAGE, OP_ALLOC_RUN: begin
                            if (i_in_req.opcode == OP_ALLOC_RUN && i_in_req.page_count > 16'd1) begin
                                r_wc    <= '0;
                                r_phase <= 1'b0;
                            end else if (v_hint_w > LAST_W) begin
                                // hint sits past the last word: go straight to the wrap pass
                                r_wc    <= '0;
                                r_phase <= 1'b1;
                            end else begin
                                r_wc    <= v_hint_w;
                                r_phase <= 1'b0;
                            end
                        end
                        OP_FREE_RUN, OP_MARK: begin
                            r_lo    <= v_lo;
                            r_hl    <= v_hi - 1'b1;
                            r_empty <= (v_lo >= v_hi);
                            r_used  <= (i_in_req.opcode == OP_MARK) && i_in_req.mark_used;
                            r_wc    <= {1'b0, v_lo[PW-1:6]};
                        end
                    endcase
                end
                CMD_SCAN_ONE: begin
                    if (v_one_hit) begin
                        r_hint <= v_one_page + 1'b1;
                        r_res  <= '{page_address: f_byte_addr(v_one_page), status: ST_DONE};
                    end else if (v_word_last) begin
                        r_wc <= '0;
                        if (!r_phase) r_phase <= 1'b1;
                        else r_res <= '{page_address: '0, status: ST_NO_MEM};
                    end else begin
                        r_wc <= r_wc + 1'b1;
                    end
                end
                CMD_RUN_WORD: begin
                    r_chunk <= '0;
                    if (&r_rd_data) begin
                        r_run <= '0;
                        r_wc  <= r_wc + 1'b1;
                        if (v_word_last) r_res <= '{page_address: '0, status: ST_NO_MEM};
                    end
                end
                CMD_RUN_CHUNK: begin
                    r_run   <= v_run;
                    r_first <= v_first;
                    if (v_found) begin
                        // claim the run through the range writer
                        r_lo    <= v_first;
                        r_hl    <= v_end;
                        r_empty <= 1'b0;
                        r_used  <= 1'b1;
                        r_wc    <= {1'b0, v_first[PW-1:6]};
                        r_res   <= '{page_address: f_byte_addr(v_first), status: ST_DONE};
                    end else begin
                        r_chunk <= r_chunk + 1'b1;
                        if (r_chunk == 3'd7) begin
                            r_wc <= r_wc + 1'b1;
                            if (v_word_last) r_res <= '{page_address: '0, status: ST_NO_MEM};
                        end
                    end
                end
                CMD_WRITE: r_wc <= r_wc + 1'b1;
            endcase
        end
    end

    assign o_status = '{
        clear_last:  v_word_last,
        word_last:   v_word_last,
        wrapped:     r_phase,
        one_hit:     v_one_hit,
        run_hit:     v_found,
        word_full:   &r_rd_data,
        chunk_last:  (r_chunk == 3'd7),
        range_empty: r_empty,
        range_last:  (r_wc == v_hl_w)
    };

    assign o_rsp = r_res;

endmodule

// ===== design/bitmap_page_allocator_core.sv =====
// Bitmap page allocator: one used bit per page with next-fit and first-fit search.
// Top level; depends on bpa_pkg, bpa_ctrl and bpa_dp.
//
// Usage: requests enter on i_in_valid/o_in_ready with an opcode (alloc page,
// alloc run, free run, mark region); each request returns exactly one response
// on o_out_valid/i_out_ready with a byte address and a status.
// The bitmap lives in a memory of 64-bit words. The unit works on one request
// at a time; o_in_ready is high only while it is idle.
// Request flow: single-page alloc reads each word scanned, then searches it,
// from the hint word on to the last word and, on a miss, once more from word
// zero; run alloc skips a fully used word and searches any other one byte per
// cycle, then writes the run word by word (read, then write); free and mark
// read and write each word touched. A final state hands the response to the
// output register once it is free. The read port gives one word per cycle.
// After reset a clearing pass writes every word to all ones (all pages
// reserved), with o_in_ready low.
// The response sits in an output register; a stalled receiver holds it and
// blocks only the hand-off of the following response.
// PAGE_BYTES must be a power of two.
module bitmap_page_allocator_core #(
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bpa_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bpa_pkg::t_rsp o_out_rsp
);
    import bpa_pkg::*;

    t_cmd       cmd;
    t_dp_status dp_status;
    t_rsp       dp_rsp;
    logic       fin;
    logic       out_free;
    logic       r_out_valid;
    t_rsp       r_out_rsp;

    assign out_free = !r_out_valid || i_out_ready;

    bpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (i_in_req),
        .i_out_free (out_free),
        .i_status   (dp_status),
        .o_cmd      (cmd),
        .o_fin      (fin)
    );

    bpa_dp #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_in_req (i_in_req),
        .o_status (dp_status),
        .o_rsp    (dp_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) r_out_rsp <= dp_rsp;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

// ===== design/bpa_checker.sv =====
// Port-level checks for the bitmap page allocator, bound to the top level.
// Depends on bpa_pkg and bitmap_page_allocator_core_macros.svh.
`include "bitmap_page_allocator_core_macros.svh"

module bpa_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input bpa_pkg::t_rsp o_out_rsp
);
    import bpa_pkg::*;

    logic [1:0] r_pending;

    // requests taken but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
        end else begin
            r_pending <= r_pending + 2'(i_in_valid && o_in_ready)
                                   - 2'(o_out_valid && i_out_ready);
        end
    end

    `BPA_ASSERT_NEXT(a_rsp_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_rsp), "response dropped or changed while stalled")
    `BPA_ASSERT_NOW(a_status_code, o_out_valid, o_out_rsp.status == ST_DONE || o_out_rsp.status == ST_NO_MEM || o_out_rsp.status == ST_IGNORED, "bad status code")
    `BPA_ASSERT_NOW(a_fail_addr, o_out_valid && o_out_rsp.status != ST_DONE, o_out_rsp.page_address == 27'd0, "nonzero address on failed request")
    `BPA_ASSERT_NOW(a_no_orphan, o_out_valid, r_pending != 2'd0, "response without a request")
    `BPA_ASSERT_NOW(a_bounded, 1'b1, r_pending <= 2'd2, "too many requests in flight")

endmodule

bind bitmap_page_allocator_core bpa_checker u_bpa_checker (.*);

// ===== test/bitmap_page_allocator_core_checker.sv =====
`timescale 1ns / 1ps
// Response checker for the bitmap page allocator: keeps its own page bitmap and
// next-fit pointer, predicts every response and compares it. Depends on bpa_pkg.
module bitmap_page_allocator_core_checker #(
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  bpa_pkg::t_req i_in_req,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  bpa_pkg::t_rsp i_out_rsp,
    output int            o_err_count,
    output int            o_pending,
    output int            o_checked
);
    import bpa_pkg::*;

    bit   page_used [NUM_PAGES];
    int   next_fit;
    t_rsp expected_rsps[$];
    int   mismatches;
    int   checked;

    initial begin
        foreach (page_used[p]) page_used[p] = 1'b1;
        next_fit   = 0;
        mismatches = 0;
        checked    = 0;
    end

    assign o_err_count = mismatches;
    assign o_pending   = expected_rsps.size();
    assign o_checked   = checked;

    function automatic t_rsp page_rsp(longint page, logic [1:0] st);
        t_rsp   r;
        longint byte_addr;
        byte_addr      = page * PAGE_BYTES;
        r.page_address = byte_addr[26:0];
        r.status       = st;
        return r;
    endfunction

    function automatic t_rsp alloc_next_fit();
        for (int p = next_fit; p < NUM_PAGES; p++) begin
            if (!page_used[p]) begin
                page_used[p] = 1'b1;
                next_fit = p + 1;
                return page_rsp(p, ST_DONE);
            end
        end
        for (int p = 0; p < next_fit && p < NUM_PAGES; p++) begin
            if (!page_used[p]) begin
                page_used[p] = 1'b1;
                next_fit = p + 1;
                return page_rsp(p, ST_DONE);
            end
        end
        return page_rsp(0, ST_NO_MEM);
    endfunction

    function automatic t_rsp alloc_first_fit(int count);
        int run;
        int first;
        run   = 0;
        first = 0;
        for (int p = 0; p < NUM_PAGES; p++) begin
            if (page_used[p]) begin
                run = 0;
                continue;
            end
            if (run == 0) first = p;
            run++;
            if (run >= count) begin
                for (int i = first; i < first + count; i++) page_used[i] = 1'b1;
                return page_rsp(first, ST_DONE);
            end
        end
        return page_rsp(0, ST_NO_MEM);
    endfunction

    function automatic t_rsp apply_request(t_req r);
        longint unsigned a;
        longint unsigned first;
        longint unsigned last;
        case (r.opcode)
            OP_ALLOC_PAGE: return alloc_next_fit();
            OP_ALLOC_RUN: begin
                if (r.page_count == 0) return page_rsp(0, ST_IGNORED);
                if (r.page_count == 1) return alloc_next_fit();
                return alloc_first_fit(r.page_count);
            end
            OP_FREE_RUN: begin
                for (int i = 0; i < r.page_count; i++) begin
                    a = longint'(r.byte_address) + longint'(i) * PAGE_BYTES;
                    if (a == 0) continue;
                    // addresses only grow, so stop once past the last page
                    if (a / PAGE_BYTES >= NUM_PAGES) break;
                    page_used[a / PAGE_BYTES] = 1'b0;
                end
                return page_rsp(0, ST_DONE);
            end
            default: begin
                first = longint'(r.byte_address) / PAGE_BYTES;
                last  = (longint'(r.byte_address) + longint'(r.region_length)
                         + PAGE_BYTES - 1) / PAGE_BYTES;
                if (last > NUM_PAGES) last = NUM_PAGES;
                for (longint unsigned p = first; p < last; p++)
                    page_used[p] = r.mark_used;
                return page_rsp(0, ST_DONE);
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                checked++;
                if (expected_rsps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected response addr=%h status=%0d", $time,
                                 i_out_rsp.page_address, i_out_rsp.status);
                end else begin
                    want = expected_rsps.pop_front();
                    if (want.page_address !== i_out_rsp.page_address ||
                        want.status !== i_out_rsp.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: response mismatch: exp addr=%h status=%0d, got addr=%h status=%0d",
                                     $time, want.page_address, want.status,
                                     i_out_rsp.page_address, i_out_rsp.status);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_rsps.push_back(apply_request(i_in_req));
        end
    end
endmodule

// ===== test/bitmap_page_allocator_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for bitmap_page_allocator_core: clock, reset, request stimulus,
// receiver stalls and verdict. Depends on bpa_pkg and the response checker.
module bitmap_page_allocator_core_tb;
    import bpa_pkg::*;

    localparam int     NUM_PAGES  = 32768;
    localparam int     PAGE_BYTES = 4096;
    localparam longint LIMIT      = 60_000_000;
    localparam int     N_RANDOM   = 1530;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_in_valid = 1'b0;
    logic  o_in_ready;
    t_req  i_in_req = '0;
    logic  o_out_valid;
    logic  i_out_ready = 1'b0;
    t_rsp  o_out_rsp;

    int     err_count, pending, checked;
    longint cycles = 0;
    int     sent = 0;
    int     burst_left = 0;
    int     hold_left = 0;
    bit     hold_start = 0;
    int     rx_mode = 0, rx_mode_left = 0;

    always #5 i_clk = ~i_clk;

    bitmap_page_allocator_core #(.NUM_PAGES(NUM_PAGES), .PAGE_BYTES(PAGE_BYTES)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_req(i_in_req),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_rsp(o_out_rsp)
    );

    bitmap_page_allocator_core_checker #(.NUM_PAGES(NUM_PAGES), .PAGE_BYTES(PAGE_BYTES)) chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in_req(i_in_req),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out_rsp(o_out_rsp),
        .o_err_count(err_count), .o_pending(pending), .o_checked(checked)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: random stall patterns, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_start) begin
            hold_start = 0;
            hold_left = 800;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(20, 200);
            end
            rx_mode_left--;
            case (rx_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom_range(0, 1));
                default: i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_request(t_req r);
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (!o_in_ready);
        sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // close the burst, idle, then pick the next burst length
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    function automatic t_req build(logic [1:0] op, longint addr, int count, longint len,
                                   bit used);
        t_req r;
        r.opcode        = op;
        r.byte_address  = addr[47:0];
        r.page_count    = count[15:0];
        r.region_length = len[47:0];
        r.mark_used     = used;
        return r;
    endfunction

    function automatic longint rand48();
        return {$urandom_range(0, 16'hFFFF), $urandom()};
    endfunction

    function automatic t_req random_request();
        int     sel;
        longint pg;
        sel = $urandom_range(0, 99);
        pg  = $urandom_range(0, 1023);
        if (sel < 10) return build(2'($urandom_range(0, 3)), rand48(),
                                   $urandom_range(0, 16'hFFFF), rand48(),
                                   1'($urandom_range(0, 1)));
        if (sel < 40) return build(OP_ALLOC_PAGE, rand48(), $urandom_range(0, 16'hFFFF),
                                   rand48(), 1'($urandom_range(0, 1)));
        if (sel < 62) return build(OP_ALLOC_RUN, 0, ($urandom_range(0, 9) == 0) ?
                                   $urandom_range(0, 64) : $urandom_range(2, 8), 0, 0);
        if (sel < 85) return build(OP_FREE_RUN, pg * PAGE_BYTES + (($urandom_range(0, 3) == 0) ?
                                   $urandom_range(0, PAGE_BYTES - 1) : 0),
                                   $urandom_range(0, 12), 0, 0);
        if (sel < 92) return build(OP_MARK, pg * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1),
                                   0, $urandom_range(0, 16 * PAGE_BYTES), 1'b0);
        return build(OP_MARK, pg * PAGE_BYTES, 0, $urandom_range(0, 8 * PAGE_BYTES), 1'b1);
    endfunction

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // everything reserved: no page to hand out
        send_request(build(OP_ALLOC_PAGE, 0, 0, 0, 0));
        send_request(build(OP_ALLOC_RUN, 0, 0, 0, 0));
        send_request(build(OP_ALLOC_RUN, 0, 2, 0, 0));
        // open the first 64 pages; page 0 comes back first
        send_request(build(OP_MARK, 0, 0, 64 * PAGE_BYTES, 1'b0));
        send_request(build(OP_ALLOC_PAGE, 0, 0, 0, 0));
        send_request(build(OP_ALLOC_RUN, 0, 1, 0, 0));
        send_request(build(OP_ALLOC_RUN, 0, 3, 0, 0));
        // freeing from address zero skips page zero
        send_request(build(OP_FREE_RUN, 0, 2, 0, 0));
        send_request(build(OP_ALLOC_RUN, 0, 2, 0, 0));
        send_request(build(OP_FREE_RUN, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 0, 0));
        send_request(build(OP_MARK, 48'hFFFF_FFFF_FFFF, 0, 48'hFFFF_FFFF_FFFF, 1'b1));
        send_request(build(OP_MARK, 5 * PAGE_BYTES + 7, 0, 0, 1'b1));
        send_request(build(OP_MARK, 6 * PAGE_BYTES, 0, 0, 1'b1));
        send_request(build(OP_ALLOC_RUN, 0, 32768, 0, 0));
        send_request(build(OP_ALLOC_RUN, 0, 16'hFFFF, 0, 0));
        // whole memory free, then take all of it in one run
        send_request(build(OP_MARK, 0, 0, 48'hFFFF_FFFF_FFFF, 1'b0));
        send_request(build(OP_ALLOC_RUN, 0, 32768, 0, 0));
        send_request(build(OP_ALLOC_PAGE, 0, 0, 0, 0));
        send_request(build(OP_FREE_RUN, (NUM_PAGES - 2) * PAGE_BYTES, 4, 0, 0));
        send_request(build(OP_ALLOC_PAGE, 0, 0, 0, 0));
        send_request(build(OP_ALLOC_PAGE, 0, 0, 0, 0));
        send_request(build(OP_MARK, 0, 0, 512 * PAGE_BYTES, 1'b0));

        hold_start = 1;
        for (int n = 0; n < N_RANDOM; n++) begin
            // refill the low pool now and then so allocations keep landing
            if (n % 200 == 199) send_request(build(OP_MARK, 0, 0, 256 * PAGE_BYTES, 1'b0));
            else send_request(random_request());
        end
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("Sent %0d requests (page and run allocation, frees, region marks).", sent);
        $display("Checked %0d responses against the predicted bitmap state.", checked);
        if (err_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches, %0d responses missing", err_count, pending);
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
